FILE: sv/pfm_pkg.sv
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared types and constants of the period and frequency meter.
// ----------------------------------------------------------------------------
package pfm_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int PERIOD_W        = 16;
	localparam int FREQ_W          = 16;
	localparam int RATE_W          = 16;
	localparam int DIGIT_W         = 4;

	localparam logic [RATE_W-1:0]  TICK_RATE_RST = 16'd10000;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX     = 4'd9;
	localparam logic [FREQ_W-1:0]  FREQ_SHOW_MAX = 16'd99;

	// Decimal split: x / 10 == (x * 205) >> 11 for every x below 1029
	localparam int RECIP_10_MUL   = 205;
	localparam int RECIP_10_SHIFT = 11;
	localparam int TWO_DIGIT_W    = 7;
	localparam int TEN            = 10;

	localparam int DIV_STEPS = FREQ_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic cnt_load;
		logic cnt_inc;
		logic div_start;
		logic div_step;
		logic out_load;
	} pfm_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_last;
		logic out_free;
	} pfm_status_t;

endpackage

FILE: sv/pfm_dp.sv
// ----------------------------------------------------------------------------
// pfm_dp
// Tick counter, bit-serial restoring divider, decimal split and result register.
// ----------------------------------------------------------------------------
module pfm_dp import pfm_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [RATE_W-1:0]   cfg_wr_data,
	input  pfm_cmd_t            cmd,
	output pfm_status_t         status,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [PERIOD_W-1:0] period_ticks,
	output logic [FREQ_W-1:0]   frequency,
	output logic [DIGIT_W-1:0]  tens_digit,
	output logic [DIGIT_W-1:0]  units_digit,
	output logic                overrange
);

	logic [RATE_W-1:0]      tick_rate_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [PERIOD_W-1:0]    period_clamp;
	logic [PERIOD_W-1:0]    divisor_q;
	logic [FREQ_W-1:0]      rem_q;
	logic [FREQ_W-1:0]      quo_q;
	logic [DIV_CNT_W-1:0]   step_q;
	logic [FREQ_W:0]        shifted;
	logic                   ge;
	logic [FREQ_W:0]        diff;

	logic [TWO_DIGIT_W-1:0]                q7;
	logic [TWO_DIGIT_W+8-1:0]              tens_prod;
	logic [DIGIT_W-1:0]                    tens_val;
	logic [TWO_DIGIT_W-1:0]                units_full;
	logic                                  over;

	logic                   out_valid_q;
	logic [PERIOD_W-1:0]    period_q;
	logic [FREQ_W-1:0]      freq_q;
	logic [DIGIT_W-1:0]     tens_q;
	logic [DIGIT_W-1:0]     units_q;
	logic                   over_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= TICK_RATE_RST;
		end else if (cfg_wr_en) begin
			tick_rate_q <= cfg_wr_data;
		end
	end

	// Tick counter, saturating at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_load) begin
			count_q <= COUNT_WIDTH'(1);
		end else if (cmd.cnt_inc && (count_q != '1)) begin
			count_q <= count_q + COUNT_WIDTH'(1);
		end
	end

	generate
		if (COUNT_WIDTH > PERIOD_W) begin : g_clamp
			assign period_clamp = (|count_q[COUNT_WIDTH-1:PERIOD_W]) ? '1
				: count_q[PERIOD_W-1:0];
		end else begin : g_extend
			assign period_clamp = PERIOD_W'(count_q);
		end
	endgenerate

	// Restoring division, one quotient bit a cycle; a zero divisor yields all ones
	assign shifted = {rem_q, quo_q[FREQ_W-1]};
	assign ge      = shifted >= {1'b0, divisor_q};
	assign diff    = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			divisor_q <= period_clamp;
			rem_q     <= '0;
			quo_q     <= tick_rate_q;
			step_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
			quo_q  <= {quo_q[FREQ_W-2:0], ge};
			step_q <= step_q + DIV_CNT_W'(1);
		end
	end

	assign status.div_last = (step_q == DIV_CNT_W'(DIV_STEPS - 1));

	// Decimal split of a quotient below one hundred
	assign q7         = quo_q[TWO_DIGIT_W-1:0];
	assign tens_prod  = (TWO_DIGIT_W+8)'(q7) * (TWO_DIGIT_W+8)'(RECIP_10_MUL);
	assign tens_val   = tens_prod[RECIP_10_SHIFT +: DIGIT_W];
	assign units_full = q7 - TWO_DIGIT_W'(tens_val) * TWO_DIGIT_W'(TEN);
	assign over       = quo_q > FREQ_SHOW_MAX;

	// Result register
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			period_q <= divisor_q;
			freq_q   <= quo_q;
			tens_q   <= over ? DIGIT_MAX : tens_val;
			units_q  <= over ? DIGIT_MAX : units_full[DIGIT_W-1:0];
			over_q   <= over;
		end
	end

	assign out_valid    = out_valid_q;
	assign period_ticks = period_q;
	assign frequency    = freq_q;
	assign tens_digit   = tens_q;
	assign units_digit  = units_q;
	assign overrange    = over_q;

endmodule

FILE: sv/pfm_ctrl.sv
// ----------------------------------------------------------------------------
// pfm_ctrl
// Edge-tracking phase machine and sequencer for the divide and the result.
// ----------------------------------------------------------------------------
module pfm_ctrl import pfm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        signal_level,
	input  pfm_status_t status,
	output pfm_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} ctrl_state_t;

	typedef enum logic [3:0] {
		PH_WAIT_LOW  = 4'b0001,
		PH_WAIT_HIGH = 4'b0010,
		PH_HIGH      = 4'b0100,
		PH_LOW       = 4'b1000
	} phase_t;

	ctrl_state_t state_q, state_d;
	phase_t      phase_q, phase_d;
	logic        accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (phase_q)
						PH_WAIT_LOW: begin
							if (!signal_level) phase_d = PH_WAIT_HIGH;
						end
						PH_WAIT_HIGH: begin
							if (signal_level) begin
								cmd.cnt_load = 1'b1;
								phase_d      = PH_HIGH;
							end
						end
						PH_HIGH: begin
							cmd.cnt_inc = 1'b1;
							if (!signal_level) phase_d = PH_LOW;
						end
						PH_LOW: begin
							if (!signal_level) begin
								cmd.cnt_inc = 1'b1;
							end else begin
								cmd.div_start = 1'b1;
								phase_d       = PH_WAIT_LOW;
								state_d       = ST_DIV;
							end
						end
						default: phase_d = PH_WAIT_LOW;
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_WAIT_LOW;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	a_start_enters_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_DIV))
		else $error("divide start did not enter the divide state");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result loaded over an untaken result");

	a_resync_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (phase_q == PH_WAIT_LOW))
		else $error("phase not resynchronising while a result is in work");

	a_emit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ($past(state_q) == ST_DIV || $past(state_q) == ST_EMIT))
		else $error("result state reached without a divide");

endmodule

FILE: sv/period_frequency_meter.sv
// A sample that does not close a period leaves ready high. A closing sample holds ready low
// while the divider forms the 16-bit quotient, one quotient bit a cycle, and then until the
// result register is loaded with the quotient and its split digits; the next sample is taken
// after that load. The load waits while an untaken result still fills the register. Reset
// (arst_n low, asynchronous): phase waits for low, count clears, tick_rate reads 10000.
// ----------------------------------------------------------------------------
// period_frequency_meter
// Reciprocal frequency counter: measures the period of a sampled signal in
// ticks and derives frequency, BCD tens and units digits and an overrange flag.
// ----------------------------------------------------------------------------
module period_frequency_meter import pfm_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration: tick_rate
	input  logic                cfg_wr_en,
	input  logic [RATE_W-1:0]   cfg_wr_data,
	// sample request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                signal_level,
	// result request channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PERIOD_W-1:0] period_ticks,
	output logic [FREQ_W-1:0]   frequency,
	output logic [DIGIT_W-1:0]  tens_digit,
	output logic [DIGIT_W-1:0]  units_digit,
	output logic                overrange
);

	// Controller and datapath talk only through these two groups
	pfm_cmd_t    cmd;
	pfm_status_t status;

	// Sequencer: track low, rise, high and low phases of the signal; on the
	// closing rise, launch the divide, then park the result once the register
	// has room.
	pfm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.signal_level (signal_level),
		.status       (status),
		.cmd          (cmd)
	);

	// Datapath: saturating tick counter, clamp to 16 bits, divide tick_rate
	// by the period, split into two decimal digits or flag overrange.
	pfm_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.period_ticks (period_ticks),
		.frequency    (frequency),
		.tens_digit   (tens_digit),
		.units_digit  (units_digit),
		.overrange    (overrange)
	);

endmodule

FILE: tb/period_frequency_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// period_frequency_meter_tb
// Drives the period and frequency meter with sampled signal levels: first a
// short table of sweeps covering the frequency edges, then random period
// trains over several tick_rate settings. Every reading is checked field by
// field against a predictor kept in step with the block.
// ----------------------------------------------------------------------------
module period_frequency_meter_tb;
	import pfm_pkg::*;

	localparam int          HALF_PERIOD    = 5;
	localparam int          RESET_CYCLES   = 12;
	localparam int          SETTLE_CYCLES  = 24;      // longer than the divide and the result load
	localparam int          HOLD_CYCLES    = 400;
	localparam int          PHASE_SAMPLES  = 120;
	localparam int          PHASE_READINGS = 8;
	localparam int          NUM_PHASES     = 8;
	localparam int          IDLE_PERCENT   = 25;
	localparam longint      LIMIT_NS       = 64'd10_000_000;

	// Synchroniser and counting phases of the meter
	typedef enum logic [1:0] {
		SEEK_LOW,
		SEEK_HIGH,
		COUNT_HIGH,
		COUNT_LOW
	} meter_phase_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [FREQ_W-1:0]   freq;
		logic [DIGIT_W-1:0]  tens;
		logic [DIGIT_W-1:0]  units;
		logic                over;
	} reading_t;

	// One row of the directed sweep: a run of equal samples, the last of which
	// may carry a hand-written reading
	typedef struct packed {
		logic        level;
		logic [16:0] reps;
		logic        typed;
		reading_t    want;
	} sweep_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_wr_en    = 1'b0;
	logic [RATE_W-1:0]   cfg_wr_data  = '0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic                signal_level = 1'b0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [PERIOD_W-1:0] period_ticks;
	logic [FREQ_W-1:0]   frequency;
	logic [DIGIT_W-1:0]  tens_digit;
	logic [DIGIT_W-1:0]  units_digit;
	logic                overrange;

	// Predictor state, mirrors the block's
	meter_phase_t                 meter_phase = SEEK_LOW;
	logic [COUNT_WIDTH_DEF-1:0]   tick_tally  = '0;
	logic [RATE_W-1:0]            rate_copy   = TICK_RATE_RST;

	reading_t pending_readings [$];
	sweep_t   sweep_q [$];
	reading_t pinned;
	bit       pin_next       = 1'b0;
	bit       steady         = 1'b0;   // no idling on either side
	bit       hold_ask       = 1'b0;   // ask the receiver for a long hold-off
	int       mismatch_count = 0;
	int       useful_samples = 0;
	int       readings_made  = 0;

	period_frequency_meter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.signal_level (signal_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.period_ticks (period_ticks),
		.frequency    (frequency),
		.tens_digit   (tens_digit),
		.units_digit  (units_digit),
		.overrange    (overrange)
	);

	always #HALF_PERIOD clk = ~clk;

	// Advance the predictor by one sample; return 1 when the sample closes a
	// period, with the reading it produces
	function automatic bit measure_sample(input logic level, output reading_t r);
		logic [PERIOD_W-1:0] span;
		logic [FREQ_W-1:0]   f;
		r = '0;
		case (meter_phase)
			SEEK_LOW: begin
				if (!level)
					meter_phase = SEEK_HIGH;
				return 1'b0;
			end
			SEEK_HIGH: begin
				if (level) begin
					tick_tally  = COUNT_WIDTH_DEF'(1); // the rising-edge tick is part of the period
					meter_phase = COUNT_HIGH;
				end
				return 1'b0;
			end
			COUNT_HIGH: begin
				if (tick_tally != '1)
					tick_tally = tick_tally + 1'b1;
				if (!level)
					meter_phase = COUNT_LOW;
				return 1'b0;
			end
			default: begin
				if (!level) begin
					if (tick_tally != '1)
						tick_tally = tick_tally + 1'b1;
					return 1'b0;
				end
			end
		endcase
		// Rising edge while counting low: the period is closed
		span = (tick_tally > {PERIOD_W{1'b1}}) ? {PERIOD_W{1'b1}} : PERIOD_W'(tick_tally);
		if (span == '0)
			f = '1;
		else
			f = FREQ_W'(rate_copy / span);
		r.period = span;
		r.freq   = f;
		if (f > FREQ_SHOW_MAX) begin
			r.over  = 1'b1;
			r.tens  = DIGIT_MAX;
			r.units = DIGIT_MAX;
		end else begin
			r.over  = 1'b0;
			r.tens  = DIGIT_W'(f / TEN);
			r.units = DIGIT_W'(f % TEN);
		end
		meter_phase = SEEK_LOW;
		tick_tally  = '0;
		return 1'b1;
	endfunction

	function automatic void add_sweep(input logic level, input int reps, input bit typed,
			input int period, input int freq, input int tens, input int units, input bit over);
		sweep_t row;
		row.level      = level;
		row.reps       = 17'(reps);
		row.typed      = typed;
		row.want.period = PERIOD_W'(period);
		row.want.freq   = FREQ_W'(freq);
		row.want.tens   = DIGIT_W'(tens);
		row.want.units  = DIGIT_W'(units);
		row.want.over   = over;
		sweep_q.push_back(row);
	endfunction

	// Offer one sample request, idling first at random; keep valid high across
	// back-to-back requests so it is never lowered and raised in one step
	task automatic offer_sample(input logic level);
		reading_t r;
		bit       made;
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		signal_level <= level;
		do
			@(posedge clk);
		while (!in_ready);
		// A high sample while seeking low is simply dropped by the block
		if (!(meter_phase == SEEK_LOW && level))
			useful_samples++;
		made = measure_sample(level, r);
		if (pin_next)
			pending_readings.push_back(pinned);
		else if (made)
			pending_readings.push_back(r);
		if (made)
			readings_made++;
		pin_next = 1'b0;
	endtask

	// Hold requests back until every reading is in, then let the divider settle
	task automatic drain_meter();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_tick_rate(input logic [RATE_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		rate_copy    = value;
	endtask

	// One random train: mostly well-formed periods of random shape, some noise
	task automatic send_train();
		int unsigned pick;
		int          span;
		int          hi_len;
		int          lo_len;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			repeat ($urandom_range(1, 12)) offer_sample(1'($urandom_range(0, 1)));
		end else begin
			span   = (pick < 60) ? 4 : (pick < 96) ? 40 : 400;
			hi_len = $urandom_range(1, span);
			lo_len = $urandom_range(1, span);
			repeat ($urandom_range(0, 2)) offer_sample(1'b1);
			repeat ($urandom_range(1, 2)) offer_sample(1'b0);
			repeat (hi_len) offer_sample(1'b1);
			repeat (lo_len) offer_sample(1'b0);
			offer_sample(1'b1);
		end
	endtask

	// Shortest possible periods: one reading every four samples
	task automatic send_tight_periods(input int n);
		repeat (n) begin
			offer_sample(1'b0);
			offer_sample(1'b1);
			offer_sample(1'b0);
			offer_sample(1'b1);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Result side: check each accepted reading and drive out_ready, with random
	// stalls and one long hold-off counted here
	initial begin
		int       hold_left;
		reading_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_readings.size() == 0) begin
					$error("reading with none expected: period %0d frequency %0d",
						period_ticks, frequency);
					mismatch_count++;
				end else begin
					want = pending_readings.pop_front();
					check_field("period_ticks", want.period, period_ticks);
					check_field("frequency",    want.freq,   frequency);
					check_field("tens_digit",   want.tens,   tens_digit);
					check_field("units_digit",  want.units,  units_digit);
					check_field("overrange",    want.over,   overrange);
				end
			end
			if (hold_ask) begin
				hold_left = HOLD_CYCLES;
				hold_ask  = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	// Run limit
	initial begin
		#(LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stimulus
	initial begin
		logic [RATE_W-1:0] rate_plan [NUM_PHASES];
		logic [RATE_W-1:0] rate_pick;

		rate_plan = '{16'd65535, 16'd1, 16'd1000, 16'd150, 16'd0, 16'd99, 16'd0, 16'd10000};

		// Directed sweep at the reset tick_rate of 10000
		add_sweep(1'b1, 3,     0, 0,     0,    0, 0, 1'b0); // high while seeking low: dropped
		add_sweep(1'b0, 2,     0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b1, 1,     0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b0, 1,     0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b1, 1,     1, 2,     5000, 9, 9, 1'b1); // shortest period, overrange
		add_sweep(1'b1, 2,     0, 0,     0,    0, 0, 1'b0); // resync after a reading
		add_sweep(1'b0, 1,     0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b1, 100,   0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b0, 100,   0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b1, 1,     1, 200,   50,   5, 0, 1'b0);
		add_sweep(1'b0, 1,     0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b1, 50,    0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b0, 50,    0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b1, 1,     1, 100,   100,  9, 9, 1'b1); // just above two digits
		add_sweep(1'b0, 1,     0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b1, 1,     0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b0, 100,   0, 0,     0,    0, 0, 1'b0);
		add_sweep(1'b1, 1,     1, 101,   99,   9, 9, 1'b0); // largest two-digit frequency

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (sweep_q[i]) begin
			repeat (sweep_q[i].reps - 1) offer_sample(sweep_q[i].level);
			pin_next = sweep_q[i].typed;
			pinned   = sweep_q[i].want;
			offer_sample(sweep_q[i].level);
		end

		// Random trains, one tick_rate setting per phase; quiet the block first
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_meter();
			rate_pick = rate_plan[p];
			if (p == 4)
				rate_pick = RATE_W'($urandom_range(1, 65535));
			else if (p == 6)
				rate_pick = RATE_W'($urandom_range(100, 3000));
			load_tick_rate(rate_pick);
			steady         = (p == 2);
			useful_samples = 0;
			readings_made  = 0;
			if (p == 3) begin
				// Stall the result side and keep requesting so the block backs up
				hold_ask = 1'b1;
				send_tight_periods(50);
			end
			while (useful_samples < PHASE_SAMPLES || readings_made < PHASE_READINGS)
				send_train();
		end
		steady = 1'b0;

		// Wait out the last readings, then watch for strays
		drain_meter();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
